// ===== rtl/core/clr_pkg.sv =====
// shared types and codes for the clause reducer
`timescale 1ns / 1ps
package clr_pkg;

  localparam int MAX_VARS_DEF = 1023;
  localparam int MAX_LITS_DEF = 32;

  localparam int LIT_W = 11;
  localparam int DATA_W = 16;

  // request kinds
  localparam logic [1:0] REQ_ASSIGN   = 2'd0;
  localparam logic [1:0] REQ_UNASSIGN = 2'd1;
  localparam logic [1:0] REQ_CLAUSE   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_KEPT  = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  // assignment table codes
  localparam logic [1:0] TBL_NONE  = 2'd0;
  localparam logic [1:0] TBL_TRUE  = 2'd1;
  localparam logic [1:0] TBL_FALSE = 2'd2;

  typedef struct packed {
    logic clearing;
    logic capture;
    logic exec;
    logic load_single;
    logic buf_rd;
    logic load_kept;
    logic clause_done;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
    logic clause_end;
    logic single;
    logic last_kept;
  } stat_t;

endpackage

// ===== rtl/core/clause_reducer.sv =====
// top level of the clause reducer
//
// simplifies clauses against a table of assigned variables
// input stream: s_tuser carries the request kind (assign, unassign, clause
//   literal), s_tdata the signed literal, s_tlast the end of a clause
// output stream: m_tdata carries a surviving literal (zero otherwise),
//   m_tuser the status code and the unit flag, m_tlast the final word of
//   a clause
// after reset the assignment table is cleared one entry a cycle, all
//   MAX_VARS+1 entries; s_tready stays low until that is done
// every input word is first captured while the table is read, and then
//   updates the table or the clause buffer; s_tready stays low meanwhile
// on a clause end the single outcome (satisfied, empty, overflow) is loaded
//   into the output register from the finish state; otherwise each kept
//   literal is first read into a register from the clause buffer
// one output register parts the two sides; a stalled receiver only holds
//   the block when a new result must be loaded into a full register
`timescale 1ns / 1ps
module clause_reducer #(
  parameter int MAX_VARS = clr_pkg::MAX_VARS_DEF,
  parameter int MAX_LITS = clr_pkg::MAX_LITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [clr_pkg::DATA_W-1:0]  s_tdata,  // [10:0] lit
  input  logic [1:0]                  s_tuser,  // [1:0] req_type
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [clr_pkg::DATA_W-1:0]  m_tdata,  // [10:0] out_lit
  output logic [2:0]                  m_tuser,  // [1:0] status, [2] is_unit
  output logic                        m_tlast
);
  import clr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic [1:0]       status;
  logic [LIT_W-1:0] out_lit;
  logic             is_unit;

  clr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clr_dp #(
    .MAX_VARS (MAX_VARS),
    .MAX_LITS (MAX_LITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_type    (s_tuser),
    .in_lit     (s_tdata[LIT_W-1:0]),
    .in_end     (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (status),
    .out_lit    (out_lit),
    .out_unit   (is_unit),
    .out_last   (m_tlast)
  );

  assign m_tdata = {{(DATA_W - LIT_W){1'b0}}, out_lit};
  assign m_tuser = {is_unit, status};

endmodule

// ===== rtl/core/clr_ctrl.sv =====
// controller state machine for the clause reducer
`timescale 1ns / 1ps
module clr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  clr_pkg::stat_t stat,
  output clr_pkg::cmd_t  cmd
);
  import clr_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FINISH,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR:   cmd.clearing = 1'b1;
      S_IDLE:    cmd.capture = s_tvalid;
      S_EXEC:    cmd.exec = 1'b1;
      S_FINISH: begin
        if (stat.single && stat.out_free) begin
          cmd.load_single = 1'b1;
          cmd.clause_done = 1'b1;
        end
      end
      S_EMIT_RD: cmd.buf_rd = 1'b1;
      S_EMIT_WR: begin
        if (stat.out_free) begin
          cmd.load_kept = 1'b1;
          cmd.clause_done = stat.last_kept;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: if (stat.clear_done) state <= S_IDLE;
        S_IDLE:  if (s_tvalid) state <= S_EXEC;
        S_EXEC:  state <= stat.clause_end ? S_FINISH : S_IDLE;
        S_FINISH: begin
          if (!stat.single) begin
            state <= S_EMIT_RD;
          end else if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        S_EMIT_RD: state <= S_EMIT_WR;
        S_EMIT_WR: begin
          if (stat.out_free) begin
            state <= stat.last_kept ? S_IDLE : S_EMIT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/clr_dp.sv =====
// datapath: assignment table, clause buffer, clause flags and output register
`timescale 1ns / 1ps
module clr_dp #(
  parameter int MAX_VARS = clr_pkg::MAX_VARS_DEF,
  parameter int MAX_LITS = clr_pkg::MAX_LITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  clr_pkg::cmd_t              cmd,
  output clr_pkg::stat_t             stat,
  input  logic [1:0]                 in_type,
  input  logic [clr_pkg::LIT_W-1:0]  in_lit,
  input  logic                       in_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [clr_pkg::LIT_W-1:0]  out_lit,
  output logic                       out_unit,
  output logic                       out_last
);
  import clr_pkg::*;

  localparam int VAR_W = $clog2(MAX_VARS + 1);
  localparam int IDX_W = $clog2(MAX_LITS);
  localparam int CNT_W = $clog2(MAX_LITS + 1);

  logic [1:0]       tbl [MAX_VARS + 1];
  logic [LIT_W-1:0] cbuf [MAX_LITS];

  logic [VAR_W-1:0] clr_cnt;
  logic             clr_end;

  // captured item
  logic [1:0]       type_q;
  logic [LIT_W-1:0] lit_q;
  logic             end_q;
  logic             var_ok_q;
  logic             neg_q;
  logic [VAR_W-1:0] var_q;
  logic [1:0]       tbl_q;

  logic [CNT_W-1:0] kept;
  logic [CNT_W-1:0] idx;
  logic             sat;
  logic             ovf;
  logic [LIT_W-1:0] cbuf_q;

  // literal decode on the input side
  logic [LIT_W-1:0] mag;
  logic             in_neg;
  logic             in_ok;
  logic [VAR_W-1:0] in_var;

  assign in_neg = in_lit[LIT_W-1];
  assign mag    = in_neg ? (~in_lit + 1'b1) : in_lit;
  assign in_ok  = (mag != '0) && (32'(mag) <= 32'(MAX_VARS));
  assign in_var = VAR_W'(mag);

  // evaluation of the captured literal
  logic [1:0] cur;
  logic [1:0] pol;
  logic       room;

  assign cur  = var_ok_q ? tbl_q : TBL_NONE;
  assign pol  = neg_q ? TBL_FALSE : TBL_TRUE;
  assign room = kept < CNT_W'(MAX_LITS);

  // table write port
  logic             tbl_we;
  logic [VAR_W-1:0] tbl_wa;
  logic [1:0]       tbl_wd;

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = var_q;
    tbl_wd = TBL_NONE;
    if (cmd.clearing) begin
      tbl_we = 1'b1;
      tbl_wa = clr_cnt;
    end else if (cmd.exec && var_ok_q) begin
      if (type_q == REQ_ASSIGN) begin
        tbl_we = 1'b1;
        tbl_wd = pol;
      end else if (type_q == REQ_UNASSIGN) begin
        tbl_we = 1'b1;
      end
    end
  end

  logic kept_wr;
  assign kept_wr = cmd.exec && (type_q == REQ_CLAUSE) && !sat &&
                   (cur != pol) && (cur == TBL_NONE) && room;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_wa] <= tbl_wd;
    if (cmd.capture) tbl_q <= tbl[in_var];
  end

  always_ff @(posedge clk) begin
    if (kept_wr) cbuf[kept[IDX_W-1:0]] <= lit_q;
    if (cmd.buf_rd) cbuf_q <= cbuf[idx[IDX_W-1:0]];
  end

  assign clr_end = (clr_cnt == VAR_W'(MAX_VARS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clearing && !clr_end) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_q   <= in_type;
      lit_q    <= in_lit;
      end_q    <= in_end;
      var_ok_q <= in_ok;
      neg_q    <= in_neg;
      var_q    <= in_var;
    end
  end

  // clause state
  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= '0;
      idx  <= '0;
      sat  <= 1'b0;
      ovf  <= 1'b0;
    end else if (cmd.clause_done) begin
      kept <= '0;
      idx  <= '0;
      sat  <= 1'b0;
      ovf  <= 1'b0;
    end else begin
      if (cmd.exec && (type_q == REQ_CLAUSE) && !sat) begin
        if (cur == pol) begin
          sat <= 1'b1;
        end else if (cur == TBL_NONE) begin
          if (room) kept <= kept + 1'b1;
          else ovf <= 1'b1;
        end
      end
      if (cmd.load_kept) idx <= idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_kept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_status <= sat ? ST_SAT : (ovf ? ST_OVF : ST_EMPTY);
      out_lit    <= '0;
      out_unit   <= 1'b0;
      out_last   <= 1'b1;
    end else if (cmd.load_kept) begin
      out_status <= ST_KEPT;
      out_lit    <= cbuf_q;
      out_unit   <= (kept == CNT_W'(1));
      out_last   <= stat.last_kept;
    end
  end

  assign stat.clear_done = clr_end;
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.clause_end = (type_q == REQ_CLAUSE) && end_q;
  assign stat.single     = sat || ovf || (kept == '0);
  assign stat.last_kept  = ((idx + 1'b1) == kept);

endmodule

// ===== tb/tb_clause_reducer.sv =====
// self-checking testbench for the clause reducer: directed table then random clause streams
`timescale 1ns / 1ps
module tb_clause_reducer;
  import clr_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] lit;
    logic        unit;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [10:0] lit;
    logic [5:0]  rep;
    logic        last;
    logic        typed;
    result_t     exp;
  } step_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [2:0]        m_tuser;
  logic              m_tlast;

  // model of the block
  logic [1:0]  var_state [0:MAX_VARS_DEF];
  logic [10:0] kept_lits [$];
  bit          clause_sat;
  bit          clause_ovf;

  result_t pending_results [$];
  step_t   plan [$];

  int  error_count = 0;
  int  words_sent = 0;
  int  clauses_sent = 0;
  int  long_clauses = 0;
  int  results_seen = 0;
  int  longest_hold = 0;
  bit  idle_on = 1'b1;
  bit  quiet = 1'b0;
  bit  hold_start = 1'b0;

  clause_reducer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic void simplify_word(input logic [1:0] req, input logic [10:0] lit,
                                        input logic last, ref result_t res[$]);
    int          mag;
    int          idx;
    logic [1:0]  pol;
    logic [1:0]  cur;
    mag = lit[10] ? 2048 - int'(lit) : int'(lit);
    idx = (mag > MAX_VARS_DEF) ? 0 : mag;
    pol = lit[10] ? TBL_FALSE : TBL_TRUE;
    case (req)
      REQ_ASSIGN: begin
        if (idx != 0) var_state[idx] = pol;
      end
      REQ_UNASSIGN: begin
        if (idx != 0) var_state[idx] = TBL_NONE;
      end
      REQ_CLAUSE: begin
        if (!clause_sat) begin
          cur = (idx != 0) ? var_state[idx] : TBL_NONE;
          if (cur == pol) begin
            clause_sat = 1'b1;
          end else if (cur == TBL_NONE) begin
            if (kept_lits.size() < MAX_LITS_DEF) kept_lits.push_back(lit);
            else clause_ovf = 1'b1;
          end
        end
        if (last) begin
          // satisfied wins over overflow, overflow over empty and kept
          if (clause_sat) begin
            res.push_back('{ST_SAT, 11'd0, 1'b0, 1'b1});
          end else if (clause_ovf) begin
            res.push_back('{ST_OVF, 11'd0, 1'b0, 1'b1});
          end else if (kept_lits.size() == 0) begin
            res.push_back('{ST_EMPTY, 11'd0, 1'b0, 1'b1});
          end else begin
            foreach (kept_lits[i])
              res.push_back('{ST_KEPT, kept_lits[i], kept_lits.size() == 1,
                              i == kept_lits.size() - 1});
          end
          kept_lits.delete();
          clause_sat = 1'b0;
          clause_ovf = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] req, input logic [10:0] lit, input logic last,
                           input bit typed, input result_t typed_res);
    int      gap;
    result_t got [$];
    if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(DATA_W-LIT_W){1'b0}}, lit};
    s_tuser  <= req;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    simplify_word(req, lit, last, got);
    // hand-written expectation replaces the model's on those rows
    if (typed) pending_results.push_back(typed_res);
    else foreach (got[i]) pending_results.push_back(got[i]);
    if (req != REQ_SPARE) words_sent++;
    if (req == REQ_CLAUSE && last) clauses_sent++;
  endtask

  function automatic logic [10:0] pick_lit(input int lo, input int hi);
    int v;
    if ($urandom_range(0, 9) == 0) return 11'($urandom_range(0, 2047));
    v = $urandom_range(lo, hi);
    return $urandom_range(0, 1) ? 11'(-v) : 11'(v);
  endfunction

  task automatic send_assignment();
    logic [1:0] req;
    req = ($urandom_range(0, 3) == 0) ? REQ_UNASSIGN : REQ_ASSIGN;
    send_word(req, pick_lit(1, 12), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic run_episode();
    int          n;
    int          len;
    bit          long_clause;
    logic [10:0] l;
    n = $urandom_range(0, 3);
    repeat (n) send_assignment();
    if ($urandom_range(0, 5) == 0)
      send_word(REQ_SPARE, 11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)), 1'b0, '0);
    long_clause = ($urandom_range(0, 14) == 0);
    len = long_clause ? $urandom_range(30, 34) : $urandom_range(1, 6);
    if (long_clause) long_clauses++;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) send_assignment();
      // long clauses mostly use variables the assigns rarely touch
      l = (long_clause && $urandom_range(0, 39) != 0) ? pick_lit(100, 1023) : pick_lit(1, 12);
      send_word(REQ_CLAUSE, l, i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result word with nothing expected", int'({m_tuser, m_tdata}), 0);
      return;
    end
    want = pending_results.pop_front();
    if (m_tuser[1:0] != want.status)
      report_mismatch("status", int'(m_tuser[1:0]), int'(want.status));
    if (m_tdata != {{(DATA_W-LIT_W){1'b0}}, want.lit})
      report_mismatch("out_lit", int'(m_tdata), int'(want.lit));
    if (m_tuser[2] != want.unit)
      report_mismatch("is_unit", int'(m_tuser[2]), int'(want.unit));
    if (m_tlast != want.last) report_mismatch("out_last", int'(m_tlast), int'(want.last));
    results_seen++;
  endtask

  // receiver: checks result words and drives m_tready
  always @(posedge clk) begin
    automatic bit ready_next;
    static int hold_left = 0;
    static int idle_left = 0;
    static int held = 0;
    if (!rst && m_tvalid && m_tready) check_result();
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      held++;
      ready_next = 1'b0;
    end else if (idle_left > 0) begin
      idle_left--;
      ready_next = 1'b0;
    end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
      idle_left = $urandom_range(1, 17) - 1;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    if (held > longest_hold) longest_hold = held;
    if (ready_next) held = 0;
    m_tready <= ready_next;
  end

  initial begin
    int directed_words;
    int episode_no;
    foreach (var_state[i]) var_state[i] = TBL_NONE;
    clause_sat = 1'b0;
    clause_ovf = 1'b0;

    //          req           lit    rep last typed  expected result
    plan.push_back('{REQ_CLAUSE,   1023,  1, 0, 0, '0});
    plan.push_back('{REQ_CLAUSE,  -1023,  1, 1, 0, '0});
    plan.push_back('{REQ_CLAUSE,      0,  1, 1, 1, '{ST_KEPT, 11'd0, 1'b1, 1'b1}});
    plan.push_back('{REQ_ASSIGN,      5,  1, 1, 0, '0});   // stray end mark
    plan.push_back('{REQ_ASSIGN,     -7,  1, 0, 0, '0});
    plan.push_back('{REQ_CLAUSE,      5,  1, 0, 0, '0});
    plan.push_back('{REQ_CLAUSE,     -9,  1, 1, 1, '{ST_SAT, 11'd0, 1'b0, 1'b1}});
    plan.push_back('{REQ_CLAUSE,     -5,  1, 0, 0, '0});
    plan.push_back('{REQ_CLAUSE,      7,  1, 1, 1, '{ST_EMPTY, 11'd0, 1'b0, 1'b1}});
    plan.push_back('{REQ_ASSIGN,      0,  1, 0, 0, '0});
    plan.push_back('{REQ_ASSIGN,     -5,  1, 0, 0, '0});   // flips variable 5
    plan.push_back('{REQ_CLAUSE,     -5,  1, 1, 1, '{ST_SAT, 11'd0, 1'b0, 1'b1}});
    plan.push_back('{REQ_UNASSIGN,    5,  1, 0, 0, '0});
    plan.push_back('{REQ_CLAUSE,      5,  1, 0, 0, '0});
    plan.push_back('{REQ_UNASSIGN,   -7,  1, 0, 0, '0});   // inside the clause
    plan.push_back('{REQ_CLAUSE,      7,  1, 1, 0, '0});
    plan.push_back('{REQ_SPARE,     123,  1, 1, 0, '0});
    plan.push_back('{REQ_ASSIGN,  -1024,  1, 0, 0, '0});
    plan.push_back('{REQ_CLAUSE,  -1024,  1, 1, 1, '{ST_KEPT, 11'h400, 1'b1, 1'b1}});
    plan.push_back('{REQ_CLAUSE,     11, 32, 0, 0, '0});   // fills the buffer
    plan.push_back('{REQ_CLAUSE,     11,  1, 1, 1, '{ST_OVF, 11'd0, 1'b0, 1'b1}});
    plan.push_back('{REQ_ASSIGN,   1023,  1, 0, 0, '0});
    plan.push_back('{REQ_CLAUSE,  -1023,  1, 1, 1, '{ST_EMPTY, 11'd0, 1'b0, 1'b1}});
    plan.push_back('{REQ_ASSIGN,  -1023,  1, 0, 0, '0});
    plan.push_back('{REQ_CLAUSE,  -1023,  1, 1, 1, '{ST_SAT, 11'd0, 1'b0, 1'b1}});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      repeat (plan[i].rep)
        send_word(plan[i].req, plan[i].lit, plan[i].last, plan[i].typed, plan[i].exp);
    directed_words = words_sent;

    episode_no = 0;
    while (words_sent - directed_words < 225) begin
      episode_no++;
      idle_on = ($urandom_range(0, 3) != 0);
      quiet = (words_sent - directed_words >= 185);
      // long receiver stall while words keep coming
      if (episode_no == 6) hold_start = 1'b1;
      // sender pause until the output side has drained
      if (episode_no == 12) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      run_episode();
    end
    s_tvalid <= 1'b0;
    quiet = 1'b1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("drove %0d words in %0d clauses (%0d near or past buffer size)",
             words_sent, clauses_sent, long_clauses);
    $display("checked %0d result words, longest output stall %0d cycles, %0d mismatches",
             results_seen, longest_hold, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
